// ===== sv/lrmg_pkg.sv =====
// shared types, constants and saturation helpers for the regression gradient core
package lrmg_pkg;

    localparam int NUM_FEATURES_DEF = 4;
    localparam int MAX_SAMPLES_DEF  = 65536;
    localparam int LANES            = 4;

    localparam int DATA_W  = 16;  // Q4.12 word
    localparam int FRAC_W  = 12;
    localparam int PROD_W  = 32;  // Q8.24 product
    localparam int SUM_W   = 36;  // prediction minus target before narrowing
    localparam int SQ_W    = 48;  // sum of squared residuals
    localparam int RES_W   = 32;  // sum of residuals
    localparam int FR_W    = 48;  // sum of feature times residual
    localparam int DIV_W   = 50;  // signed dividend of every mean
    localparam int COST_W  = 31;
    localparam int GRAD_W  = 32;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIAS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_3 = 3'd4;

    typedef struct packed {
        logic signed [DATA_W-1:0] feature_0;
        logic signed [DATA_W-1:0] feature_1;
        logic signed [DATA_W-1:0] feature_2;
        logic signed [DATA_W-1:0] feature_3;
        logic signed [DATA_W-1:0] target;
        logic                     last_sample;
    } t_in;

    typedef struct packed {
        logic        [COST_W-1:0] cost;
        logic signed [GRAD_W-1:0] grad_bias;
        logic signed [GRAD_W-1:0] grad_0;
        logic signed [GRAD_W-1:0] grad_1;
        logic signed [GRAD_W-1:0] grad_2;
        logic signed [GRAD_W-1:0] grad_3;
    } t_out;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic start;
    } t_lane_ctl;

    function automatic logic signed [DATA_W-1:0] sat_s16(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-DATA_W:0] hi;
        hi = v[SUM_W-1:DATA_W-1];
        if ((&hi) || !(|hi)) begin
            return v[DATA_W-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    function automatic logic signed [GRAD_W-1:0] sat_s32(input logic signed [DIV_W-1:0] v);
        logic [DIV_W-GRAD_W:0] hi;
        hi = v[DIV_W-1:GRAD_W-1];
        if ((&hi) || !(|hi)) begin
            return v[GRAD_W-1:0];
        end
        return v[DIV_W-1] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
    endfunction

    function automatic logic [COST_W-1:0] sat_u31(input logic signed [DIV_W-1:0] v);
        if (|v[DIV_W-1:COST_W]) begin
            return {COST_W{1'b1}};
        end
        return v[COST_W-1:0];
    endfunction

endpackage

// ===== sv/lrmg_div.sv =====
// iterative signed by unsigned divider, one quotient bit per cycle, truncating toward zero
module lrmg_div import lrmg_pkg::*; #(
    parameter int DEN_W = 17
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DIV_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_busy,
    output logic signed [DIV_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic              r_neg;

    logic [DEN_W:0]    w_shift;
    logic              w_fit;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_fit   = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_start) begin
            r_step <= STEP_W'(DIV_W);
        end else if (r_step != '0) begin
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[DIV_W-1];
            r_quo <= i_num[DIV_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_step != '0) begin
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
            r_rem <= w_fit ? DEN_W'(w_shift - {1'b0, r_den}) : w_shift[DEN_W-1:0];
        end
    end

    assign o_busy = (r_step != '0);
    assign o_quot = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

// ===== sv/lrmg_lane.sv =====
// one feature lane: weight product, feature-residual accumulator and gradient divider
module lrmg_lane import lrmg_pkg::*; #(
    parameter int DEN_W = 17
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_weight,
    input  logic signed [DATA_W-1:0] i_feature,
    input  logic signed [DATA_W-1:0] i_resid,
    input  logic [DEN_W-1:0]         i_den,
    output logic signed [PROD_W-1:0] o_prod,
    output logic signed [GRAD_W-1:0] o_grad,
    output logic                     o_busy
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [FR_W-1:0]   r_acc;
    logic signed [PROD_W-1:0] w_fr;
    logic signed [DIV_W-1:0]  w_num;
    logic signed [DIV_W-1:0]  w_quot;

    assign w_fr  = i_feature * i_resid;
    assign w_num = DIV_W'(r_acc) <<< 1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_weight * i_feature;
        end
    end

    // cleared as the divider takes its snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.start) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + FR_W'(w_fr);
        end
    end

    lrmg_div #(.DEN_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.start),
        .i_num   (w_num),
        .i_den   (i_den),
        .o_busy  (o_busy),
        .o_quot  (w_quot)
    );

    assign o_prod = r_prod;
    assign o_grad = sat_s32(w_quot);

endmodule

// ===== sv/linear_regression_mse_gradient_core.sv =====
// linear regression mse and gradient core: lanes, residual merge, batch divide, output word
// a sample word passes through four steps: capture, lane multiply, merge and narrow, accumulate
// no new sample word is taken until that four-step sequence is back in idle or while a batch end divides
// a last sample adds a snapshot state and DIV_W (50) quotient steps of the lane, cost and bias dividers,
// and its result word loads once all dividers are done and the output register is free
// synchronous active-low reset clears weights, bias, accumulators, count and output valid
module linear_regression_mse_gradient_core import lrmg_pkg::*; #(
    parameter int NUM_FEATURES = NUM_FEATURES_DEF,
    parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // sample words in
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    // result words out
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    // register writes
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_wdata
);

    // sample count must reach MAX_SAMPLES itself
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_SUM  = 6'b000100,
        ST_ACC  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_WAIT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // model registers
    logic signed [DATA_W-1:0] r_bias;
    logic signed [DATA_W-1:0] r_weight [LANES];

    // captured sample
    logic signed [DATA_W-1:0] r_feat [LANES];
    logic signed [DATA_W-1:0] r_target;
    logic                     r_last;

    // merge stage and batch accumulators
    logic signed [DATA_W-1:0] r_resid;
    logic        [SQ_W-1:0]   r_sq;
    logic signed [RES_W-1:0]  r_sum_res;
    logic        [CNT_W-1:0]  r_count;

    // output register
    logic                     r_out_valid;
    t_out                     r_out;

    logic                     w_in_take;
    logic                     w_out_take;
    logic                     w_room;
    logic                     w_any_busy;
    logic                     w_load;
    logic [CNT_W-1:0]         w_den;
    t_lane_ctl                w_ctl;

    logic signed [PROD_W-1:0] w_prod [LANES];
    logic signed [GRAD_W-1:0] w_grad [LANES];
    logic        [LANES-1:0]  w_lane_busy;

    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]  w_shift;
    logic signed [PROD_W-1:0] w_sq;

    logic signed [DIV_W-1:0]  w_cost_num;
    logic signed [DIV_W-1:0]  w_bias_num;
    logic signed [DIV_W-1:0]  w_cost_quot;
    logic signed [DIV_W-1:0]  w_bias_quot;
    logic                     w_cost_busy;
    logic                     w_bias_busy;

    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_room     = (r_count < CNT_W'(MAX_SAMPLES));
    assign w_any_busy = (|w_lane_busy) || w_cost_busy || w_bias_busy;
    // result leaves the dividers once all are done and the output register is free
    assign w_load     = (r_state == ST_WAIT) && !w_any_busy && (!r_out_valid || !i_out_stall);
    // a batch end always leaves a nonzero count, guard kept for safety
    assign w_den      = (r_count == '0) ? CNT_W'(1) : r_count;

    assign o_in_stall = (r_state != ST_IDLE);

    // register writes, indexes past the last weight are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0;
            for (int k = 0; k < LANES; k++) begin
                r_weight[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_BIAS:     r_bias      <= i_cfg_wdata;
                REG_WEIGHT_0: r_weight[0] <= i_cfg_wdata;
                REG_WEIGHT_1: r_weight[1] <= i_cfg_wdata;
                REG_WEIGHT_2: r_weight[2] <= i_cfg_wdata;
                REG_WEIGHT_3: r_weight[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_take) n_state = ST_MUL;
            ST_MUL:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_ACC;
            ST_ACC:  n_state = r_last ? ST_DIV : ST_IDLE;
            ST_DIV:  n_state = ST_WAIT;
            ST_WAIT: if (w_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture the sample word
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_feat[0] <= i_in_data.feature_0;
            r_feat[1] <= i_in_data.feature_1;
            r_feat[2] <= i_in_data.feature_2;
            r_feat[3] <= i_in_data.feature_3;
            r_target  <= i_in_data.target;
            r_last    <= i_in_data.last_sample;
        end
    end

    // lane controls; a full batch stops accumulating but still closes on its last sample
    assign w_ctl.mul_en = (r_state == ST_MUL);
    assign w_ctl.acc_en = (r_state == ST_ACC) && w_room;
    assign w_ctl.start  = (r_state == ST_DIV);

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        if (k < NUM_FEATURES) begin : g_on
            lrmg_lane #(.DEN_W(CNT_W)) u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_weight  (r_weight[k]),
                .i_feature (r_feat[k]),
                .i_resid   (r_resid),
                .i_den     (w_den),
                .o_prod    (w_prod[k]),
                .o_grad    (w_grad[k]),
                .o_busy    (w_lane_busy[k])
            );
        end else begin : g_off
            // lane not fitted: contributes nothing, gradient reads zero
            assign w_prod[k]      = '0;
            assign w_grad[k]      = '0;
            assign w_lane_busy[k] = 1'b0;
        end
    end

    // merge: bias plus lane products minus target, summed in Q12.24
    always_comb begin
        w_sum = SUM_W'(r_bias) <<< FRAC_W;
        for (int k = 0; k < LANES; k++) begin
            w_sum = w_sum + SUM_W'(w_prod[k]);
        end
        w_sum = w_sum - (SUM_W'(r_target) <<< FRAC_W);
    end

    // arithmetic shift rounds toward minus infinity before the Q4.12 clamp
    assign w_shift = w_sum >>> FRAC_W;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SUM) begin
            r_resid <= sat_s16(w_shift);
        end
    end

    assign w_sq = r_resid * r_resid;

    // batch accumulators, cleared as the dividers take their snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_ctl.start) begin
            r_sq      <= '0;
            r_sum_res <= '0;
            r_count   <= '0;
        end else if (w_ctl.acc_en) begin
            r_sq      <= r_sq + SQ_W'($unsigned(w_sq));
            r_sum_res <= r_sum_res + RES_W'(r_resid);
            r_count   <= r_count + 1'b1;
        end
    end

    // cost takes the squared-residual sum as is; bias takes twice the residual sum, lifted from Q20.12 to Q26.24
    assign w_cost_num = DIV_W'(r_sq);
    assign w_bias_num = DIV_W'(r_sum_res) <<< (FRAC_W + 1);

    lrmg_div #(.DEN_W(CNT_W)) u_cost_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.start),
        .i_num   (w_cost_num),
        .i_den   (w_den),
        .o_busy  (w_cost_busy),
        .o_quot  (w_cost_quot)
    );

    lrmg_div #(.DEN_W(CNT_W)) u_bias_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.start),
        .i_num   (w_bias_num),
        .i_den   (w_den),
        .o_busy  (w_bias_busy),
        .o_quot  (w_bias_quot)
    );

    // output register: holds a finished word while sampling goes on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.cost      <= sat_u31(w_cost_quot);
            r_out.grad_bias <= sat_s32(w_bias_quot);
            r_out.grad_0    <= w_grad[0];
            r_out.grad_1    <= w_grad[1];
            r_out.grad_2    <= w_grad[2];
            r_out.grad_3    <= w_grad[3];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a taken sample word always moves on to the lane multiply
    a_take_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_state == ST_MUL))
        else $error("sample word taken but lanes not started");

    // batch count never runs past its limit
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond batch limit");

    // snapshot leaves the accumulators empty
    a_clear_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |=> (r_count == '0) && (r_sq == '0) && (r_sum_res == '0))
        else $error("accumulators not cleared after batch end");

    // a new result word only comes out of the divide wait
    a_load_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_WAIT) && !$past(w_any_busy))
        else $error("result word loaded while dividers busy");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

endmodule
